// ----- hdl/ppq_pkg.sv -----
// Shared types, codes and defaults for the packet priority queue.
package ppq_pkg;

   // Default number of stored packets
   localparam int PPQ_DEPTH = 32;

   // Opcode carried on the request tuser
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DUMP   = 1'b1
   } op_type;

   // Result kind carried on the response tuser
   typedef enum logic [2:0] {
      KIND_ACCEPT     = 3'd0,
      KIND_WRONG_DEST = 3'd1,
      KIND_FULL       = 3'd2,
      KIND_ENTRY      = 3'd3,
      KIND_EMPTY      = 3'd4
   } kind_type;

   // One stored packet, priority in the lowest bits
   typedef struct packed {
      logic [31:0] payload;
      logic [31:0] dest;
      logic [31:0] src;
      logic [7:0]  prio;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ----- hdl/ppq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ppq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hdl/packet_priority_queue.sv -----
// Packet priority queue: sorted insert into a RAM, in-order dump on request.
//
//  channel | direction | tdata (low bit up)                    | tuser | tlast
//  req_    | in        | priority_req, src_addr, dest_addr, payload | op | -
//  rsp_    | out       | out_priority, out_src, out_dest, out_payload | kind | last
//  csr_    | in        | own_address (write only)              | -     | -
//
// An insert, once accepted, is decided and then scans back from the tail, moving each stored
// entry of equal or higher priority one slot down in the RAM before it writes the new packet
// into the freed slot. A rejected insert or an empty dump goes from the decision straight to
// its response; a dump reads each stored entry from the RAM, then loads it into the output.
// Reset clears the entry count and sets own_address to 1; the RAM needs no clearing.
// A stalled response holds the block where it would load the next response, until the item is taken.
module packet_priority_queue
   import ppq_pkg::*;
#(
   parameter int DEPTH = PPQ_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // priority_req, src_addr, dest_addr, payload
   input  logic [0:0]   req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // out_priority, out_src, out_dest, out_payload
   output logic [2:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SRD,
      ST_SCMP,
      ST_DRD,
      ST_DLD,
      ST_EMIT
   } state_type;

   state_type   state_ff;
   op_type      op_ff;
   entry_type   item_ff;
   logic [AW-1:0] idx_ff;
   logic [CW-1:0] count_ff;
   logic [31:0] own_address_ff;
   kind_type    kind_ff;
   logic        rsp_tvalid_ff;
   entry_type   rsp_data_ff;
   kind_type    rsp_kind_ff;
   logic        rsp_last_ff;

   logic        ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   entry_type   ram_wr_data;
   logic        ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_bits;
   entry_type   ram_rd_data;
   logic        out_free;
   logic        rsp_load;
   logic        shift;
   logic        dump_last;

   assign ram_rd_data = entry_type'(ram_rd_bits);
   assign out_free    = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load    = (state_ff == ST_DLD) || (state_ff == ST_EMIT && out_free);
   assign shift       = ram_rd_data.prio >= item_ff.prio;
   assign dump_last   = (CW'(idx_ff) + CW'(1)) == count_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Drive RAM ports from the current step
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = item_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;
      unique case (state_ff)
         ST_SRD: begin
            if (idx_ff == '0) begin
               ram_wr_en = 1'b1;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff - AW'(1);
            end
         end
         ST_SCMP: begin
            ram_wr_en = 1'b1;
            if (shift) begin
               ram_wr_data = ram_rd_data;
            end
         end
         ST_DRD: begin
            ram_rd_en = out_free;
         end
         default: begin
         end
      endcase
   end

   ppq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_bits)
   );

   // Hold state, count, config and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         own_address_ff <= 32'd1;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            own_address_ff <= csr_wr_data;
         end
         // Drop the taken response unless a new item loads in its place
         if (rsp_tvalid_ff && rsp_tready && !rsp_load) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= op_type'(req_tuser);
                  item_ff  <= entry_type'(req_tdata);
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               priority if (op_ff == OP_DUMP && count_ff == '0) begin
                  kind_ff  <= KIND_EMPTY;
                  state_ff <= ST_EMIT;
               end else if (op_ff == OP_DUMP) begin
                  idx_ff   <= '0;
                  state_ff <= ST_DRD;
               end else if (item_ff.dest != own_address_ff) begin
                  kind_ff  <= KIND_WRONG_DEST;
                  state_ff <= ST_EMIT;
               end else if (count_ff >= CW'(DEPTH)) begin
                  kind_ff  <= KIND_FULL;
                  state_ff <= ST_EMIT;
               end else begin
                  idx_ff   <= count_ff[AW-1:0];
                  state_ff <= ST_SRD;
               end
            end
            // Walk back from the tail, one entry per read
            ST_SRD: begin
               if (idx_ff == '0) begin
                  count_ff <= count_ff + CW'(1);
                  kind_ff  <= KIND_ACCEPT;
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_SCMP;
               end
            end
            // Move the entry down, or drop the new packet in its slot
            ST_SCMP: begin
               if (shift) begin
                  idx_ff   <= idx_ff - AW'(1);
                  state_ff <= ST_SRD;
               end else begin
                  count_ff <= count_ff + CW'(1);
                  kind_ff  <= KIND_ACCEPT;
                  state_ff <= ST_EMIT;
               end
            end
            ST_DRD: begin
               if (out_free) begin
                  state_ff <= ST_DLD;
               end
            end
            // Present the entry that was just read
            ST_DLD: begin
               rsp_tvalid_ff <= 1'b1;
               rsp_data_ff   <= ram_rd_data;
               rsp_kind_ff   <= KIND_ENTRY;
               rsp_last_ff   <= dump_last;
               if (dump_last) begin
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff   <= idx_ff + AW'(1);
                  state_ff <= ST_DRD;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_data_ff   <= '0;
                  rsp_kind_ff   <= kind_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Entry count stays within the RAM
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // Count only ever grows by one, and only on a RAM write
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CW'(1) && $past(ram_wr_en)))
      else $error("entry count changed without an insert");

   // Dump reads stay below the stored count
   a_dump_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRD && ram_rd_en) |-> (CW'(idx_ff) < count_ff))
      else $error("dump read beyond stored entries");

   // Only the insert scan writes the RAM
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_SRD || state_ff == ST_SCMP))
      else $error("RAM write outside insert");

   // An entry response is never loaded over one that waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |-> (state_ff != ST_DLD))
      else $error("entry response loaded over a waiting item");

endmodule

// ----- verif/packet_priority_queue_tb.sv -----
// Testbench for packet_priority_queue: directed table, random phases, queue model checks.
module packet_priority_queue_tb;
   import ppq_pkg::*;

   localparam int QDEPTH = PPQ_DEPTH;
   localparam int CLK_HALF = 5;
   localparam int RESET_CYCLES = 10;
   localparam int MAX_IDLE = 10;
   localparam int DRAIN_CYCLES = 80;     // longer than the slowest insert
   localparam int CSR_SETTLE = 4;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS = 49;
   localparam int DIR_ROWS = 20;
   localparam logic [31:0] RESET_OWN_ADDRESS = 32'h1;

   // Kind of a directed row: send an item, or write own_address (value in dest)
   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CFG  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      op_type      op;
      logic        typed;        // expected kind given in the row, fields zero
      kind_type    typed_kind;
      logic [7:0]  prio;
      logic [31:0] src;
      logic [31:0] dest;
      logic [31:0] payload;
   } stim_row_type;

   typedef struct packed {
      kind_type  kind;
      entry_type entry;
      logic      last;
   } rsp_item_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;   // priority_req, src_addr, dest_addr, payload
   logic [0:0]   req_tuser;   // op
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;   // out_priority, out_src, out_dest, out_payload
   logic [2:0]   rsp_tuser;   // kind
   logic         rsp_tlast;
   logic         csr_wr_en;
   logic [31:0]  csr_wr_data;

   // Queue model state
   entry_type    queue_entries [QDEPTH];
   int           queue_count;
   logic [31:0]  own_address;

   rsp_item_type expected_rsp [$];
   rsp_item_type step_results [$];
   stim_row_type directed_rows [DIR_ROWS];
   int           fail_count;
   logic         no_idle;

   packet_priority_queue #(
      .DEPTH(QDEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock, first rising edge after reset is driven
   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   // Compute the results of one item and advance the queue model
   function automatic void predict_queue_step(input op_type op, input logic [7:0] prio,
                                              input logic [31:0] src, input logic [31:0] dest,
                                              input logic [31:0] payload);
      rsp_item_type r;
      int           pos;
      step_results.delete();
      r.entry = '0;
      r.last = 1'b1;
      if (op == OP_DUMP) begin
         if (queue_count == 0) begin
            r.kind = KIND_EMPTY;
            step_results.push_back(r);
         end else begin
            for (int i = 0; i < queue_count; i++) begin
               r.kind = KIND_ENTRY;
               r.entry = queue_entries[i];
               r.last = (i == queue_count - 1);
               step_results.push_back(r);
            end
         end
      end else if (dest != own_address) begin
         r.kind = KIND_WRONG_DEST;
         step_results.push_back(r);
      end else if (queue_count >= QDEPTH) begin
         r.kind = KIND_FULL;
         step_results.push_back(r);
      end else begin
         // Insert before the first entry of equal or higher priority
         pos = queue_count;
         for (int i = 0; i < queue_count; i++) begin
            if (queue_entries[i].prio >= prio) begin
               pos = i;
               break;
            end
         end
         for (int i = queue_count; i > pos; i--)
            queue_entries[i] = queue_entries[i - 1];
         queue_entries[pos].prio = prio;
         queue_entries[pos].src = src;
         queue_entries[pos].dest = dest;
         queue_entries[pos].payload = payload;
         queue_count++;
         r.kind = KIND_ACCEPT;
         step_results.push_back(r);
      end
   endfunction

   // Offer one item after a random gap (none under no_idle), hold until taken, then queue its results
   task automatic send_request(input op_type op, input logic [7:0] prio,
                               input logic [31:0] src, input logic [31:0] dest,
                               input logic [31:0] payload, input logic typed,
                               input kind_type typed_kind);
      int           gap;
      rsp_item_type r;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser <= op;
      req_tdata <= {payload, dest, src, prio};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_queue_step(op, prio, src, dest, payload);
      if (typed) begin
         r.kind = typed_kind;
         r.entry = '0;
         r.last = 1'b1;
         expected_rsp.push_back(r);
      end else begin
         foreach (step_results[i]) expected_rsp.push_back(step_results[i]);
      end
   endtask

   // Drain the block, then write own_address
   task automatic write_own_address(input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      own_address = value;
   endtask

   // Response side: random stall before each item, none under no_idle
   initial begin : rsp_ready_drive
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      entry_type    got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result: kind %0d tdata %h last %b",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            got = rsp_tdata;
            if (rsp_tuser !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
               fail_count++;
            end
            if (got.prio !== want.entry.prio) begin
               $error("out_priority: expected %0d, got %0d", want.entry.prio, got.prio);
               fail_count++;
            end
            if (got.src !== want.entry.src) begin
               $error("out_src: expected %h, got %h", want.entry.src, got.src);
               fail_count++;
            end
            if (got.dest !== want.entry.dest) begin
               $error("out_dest: expected %h, got %h", want.entry.dest, got.dest);
               fail_count++;
            end
            if (got.payload !== want.entry.payload) begin
               $error("out_payload: expected %h, got %h", want.entry.payload, got.payload);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Stimulus: reset, directed table, random phases, drain
   initial begin : stimulus
      logic [31:0] phase_addr;
      logic [31:0] dest;
      logic [7:0]  prio;
      op_type      op;
      int          sel;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_INSERT;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      no_idle = 1'b0;
      fail_count = 0;
      queue_count = 0;
      own_address = RESET_OWN_ADDRESS;

      directed_rows = '{
         '{ROW_ITEM, OP_DUMP,   1'b1, KIND_EMPTY,      8'd0,   32'h0,        32'h0,
           32'h0},
         '{ROW_ITEM, OP_INSERT, 1'b1, KIND_WRONG_DEST, 8'd5,   32'h1234_5678, 32'h0,
           32'hDEAD_BEEF},
         '{ROW_ITEM, OP_INSERT, 1'b1, KIND_WRONG_DEST, 8'hFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF},
         '{ROW_ITEM, OP_INSERT, 1'b0, KIND_ACCEPT,     8'd128, 32'h0,        32'h1,
           32'h0},
         '{ROW_ITEM, OP_INSERT, 1'b0, KIND_ACCEPT,     8'd0,   32'hFFFF_FFFF, 32'h1,
           32'hFFFF_FFFF},
         '{ROW_ITEM, OP_INSERT, 1'b0, KIND_ACCEPT,     8'hFF,  32'h0,        32'h1,
           32'hA5A5_A5A5},
         '{ROW_ITEM, OP_INSERT, 1'b0, KIND_ACCEPT,     8'd128, 32'h1,        32'h1,
           32'h2},
         '{ROW_ITEM, OP_INSERT, 1'b0, KIND_ACCEPT,     8'hFF,  32'h2,        32'h1,
           32'h3},
         '{ROW_ITEM, OP_INSERT, 1'b0, KIND_ACCEPT,     8'd0,   32'h3,        32'h1,
           32'h4},
         '{ROW_ITEM, OP_DUMP,   1'b0, KIND_ENTRY,      8'd0,   32'h0,        32'h0,
           32'h0},
         '{ROW_ITEM, OP_INSERT, 1'b1, KIND_WRONG_DEST, 8'd9,   32'h5,        32'h2,
           32'h6},
         '{ROW_ITEM, OP_INSERT, 1'b0, KIND_ACCEPT,     8'd64,  32'h8000_0000, 32'h1,
           32'h0000_0001},
         '{ROW_ITEM, OP_DUMP,   1'b0, KIND_ENTRY,      8'd0,   32'h0,        32'h0,
           32'h0},
         '{ROW_CFG,  OP_INSERT, 1'b0, KIND_ACCEPT,     8'd0,   32'h0,        32'h0,
           32'h0},
         '{ROW_ITEM, OP_INSERT, 1'b0, KIND_ACCEPT,     8'd7,   32'hC3C3_C3C3, 32'h0,
           32'h3C3C_3C3C},
         '{ROW_ITEM, OP_INSERT, 1'b1, KIND_WRONG_DEST, 8'd7,   32'h0,        32'h1,
           32'h0},
         '{ROW_CFG,  OP_INSERT, 1'b0, KIND_ACCEPT,     8'd0,   32'h0,        32'hFFFF_FFFF,
           32'h0},
         '{ROW_ITEM, OP_INSERT, 1'b0, KIND_ACCEPT,     8'd200, 32'h5A5A_5A5A, 32'hFFFF_FFFF,
           32'h0},
         '{ROW_ITEM, OP_INSERT, 1'b1, KIND_WRONG_DEST, 8'd200, 32'h0,        32'h0,
           32'h0},
         '{ROW_ITEM, OP_DUMP,   1'b0, KIND_ENTRY,      8'd0,   32'h0,        32'h0,
           32'h0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG)
            write_own_address(directed_rows[i].dest);
         else
            send_request(directed_rows[i].op, directed_rows[i].prio, directed_rows[i].src,
                         directed_rows[i].dest, directed_rows[i].payload,
                         directed_rows[i].typed, directed_rows[i].typed_kind);
      end

      // Random phases, each under its own address; the queue fills early and stays full
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               phase_addr = RESET_OWN_ADDRESS;
            end
            1: begin
               phase_addr = 32'h0;
            end
            2: begin
               phase_addr = 32'hFFFF_FFFF;
            end
            default: begin
               phase_addr = $urandom;
            end
         endcase
         write_own_address(phase_addr);
         no_idle = (phase == 3) || ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            op = (sel < 12) ? OP_DUMP : OP_INSERT;
            dest = (sel < 30) ? $urandom : own_address;
            // Mix full-range priorities with a few clustered values for ties
            case ($urandom_range(0, 2))
               0: begin
                  prio = 8'($urandom_range(0, 255));
               end
               1: begin
                  prio = 8'($urandom_range(0, 3) * 85);
               end
               default: begin
                  prio = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'hFF;
               end
            endcase
            send_request(op, prio, $urandom, dest, $urandom, 1'b0, KIND_ACCEPT);
         end
      end

      // Drop valid, wait for the last results, then let the block settle
      req_tvalid <= 1'b0;
      no_idle = 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("packet_priority_queue_tb passed");
      else
         $display("packet_priority_queue_tb failed");
      $finish;
   end

   // Hard stop if the run hangs
   initial begin : watchdog
      #10_000_000;
      $display("packet_priority_queue_tb failed");
      $finish;
   end

endmodule

// ----- packet_priority_queue.f -----
hdl/ppq_pkg.sv
hdl/ppq_ram.sv
hdl/packet_priority_queue.sv
verif/packet_priority_queue_tb.sv
